// ===== hdl/key_hash_tag_shard_router_macros.svh =====
// assertion macros shared by the router checker
`ifndef KEY_HASH_TAG_SHARD_ROUTER_MACROS_SVH
`define KEY_HASH_TAG_SHARD_ROUTER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define KHR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define KHR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/khr_pkg.sv =====
// shared types and constants of the key hash tag shard router
package khr_pkg;

   localparam int unsigned MaxShardsDefault = 256;

   localparam int CountW = 9;
   localparam int SlotW  = 14;
   localparam int IndexW = 8;
   localparam int CrcW   = 16;
   localparam int ByteW  = 8;
   localparam int DivW   = 32;
   localparam int StepW  = 6;

   localparam logic [StepW-1:0] KeySteps = StepW'(SlotW);
   localparam logic [StepW-1:0] RrSteps  = StepW'(DivW);

   localparam logic [CrcW-1:0]  CrcPoly    = 16'h1021;
   localparam logic [ByteW-1:0] OpenBrace  = 8'h7B;
   localparam logic [ByteW-1:0] CloseBrace = 8'h7D;

   localparam logic OpKeyByte    = 1'b0;
   localparam logic OpRoundRobin = 1'b1;

   typedef enum logic [1:0] {
      TAG_SEEK,
      TAG_INSIDE,
      TAG_CLOSED
   } tag_phase_type;

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } router_state_type;

   typedef struct packed {
      logic             fold;
      logic             last;
      logic [ByteW-1:0] key_byte;
   } crc_cmd_type;

   typedef struct packed {
      logic              start;
      logic [DivW-1:0]   dividend;
      logic [StepW-1:0]  steps;
      logic [CountW-1:0] divisor;
   } mod_cmd_type;

   typedef struct packed {
      logic              busy;
      logic [CountW-1:0] remainder;
   } mod_status_type;

endpackage

// ===== hdl/khr_req_if.sv =====
// request channel: key bytes and round-robin requests
interface khr_req_if import khr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             operation;
   logic [ByteW-1:0] key_byte;
   logic             last_byte;

   modport source (output valid, output operation, output key_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input operation, input key_byte, input last_byte,
                   output ready);
endinterface

// ===== hdl/khr_rsp_if.sv =====
// response channel: chosen shard and slot
interface khr_rsp_if import khr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IndexW-1:0] shard_index;
   logic [SlotW-1:0]  hash_slot;
   logic              no_shard;
   logic              by_round_robin;

   modport source (output valid, output shard_index, output hash_slot, output no_shard,
                   output by_round_robin, input ready);
   modport sink   (input valid, input shard_index, input hash_slot, input no_shard,
                   input by_round_robin, output ready);
endinterface

// ===== hdl/key_hash_tag_shard_router.sv =====
// top level of the key hash tag shard router
//
// req_bus carries one key byte per beat (operation 0) or a keyless
// round-robin request (operation 1); last_byte closes a key. rsp_bus returns
// one beat per closed key or round-robin request. csr_wr_en / csr_wr_data set
// the shard count; the user must write it only when idle, with no guard here.
//
// key bytes that do not close a key are taken back to back, one per cycle,
// while the router is idle. a closing byte runs the slot remainder for 14
// steps on the shared bit-serial remainder unit; the result is loaded into
// the output register once that register is free, and the next request is
// taken after that load. a round-robin request runs 32 steps on the same
// unit (32-bit counter) and is answered the same way.
//
// reset clears the key checksums, the round-robin counter, the shard count
// and the response valid. a stalled response sits in the output register
// while further non-closing key bytes are still taken; a finished remainder
// waits in the unit until the output register frees up
module key_hash_tag_shard_router import khr_pkg::*; #(
   parameter int unsigned MAX_SHARDS = MaxShardsDefault
) (
   input  logic              clock,
   input  logic              reset,
   khr_req_if.sink           req_bus,
   khr_rsp_if.source         rsp_bus,
   input  logic              csr_wr_en,
   input  logic [CountW-1:0] csr_wr_data
);

   // sequencer state
   router_state_type state_ff, state_in;

   // shard count register and its saturated view
   logic [CountW-1:0] count_ff, count_in;
   logic [CountW-1:0] eff_count;

   // round-robin counter, advanced on each round-robin pick
   logic [DivW-1:0] rr_ff, rr_in;

   // job fields carried across the division
   logic             job_rr_ff, job_rr_in;
   logic             job_none_ff, job_none_in;
   logic [SlotW-1:0] job_slot_ff, job_slot_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IndexW-1:0] rsp_index_ff, rsp_index_in;
   logic [SlotW-1:0]  rsp_slot_ff, rsp_slot_in;
   logic              rsp_none_ff, rsp_none_in;
   logic              rsp_rr_ff, rsp_rr_in;

   logic             req_accept;
   logic             job_start;
   logic             rsp_free;
   logic             rsp_load;
   logic [SlotW-1:0] key_slot;

   crc_cmd_type    crc_cmd;
   mod_cmd_type    mod_cmd;
   mod_status_type mod_status;

   assign eff_count = (32'(count_ff) > 32'(MAX_SHARDS)) ? CountW'(MAX_SHARDS) : count_ff;

   assign req_accept = req_bus.valid && req_bus.ready;
   // a round-robin request or a closing byte needs a remainder
   assign job_start  = req_accept && (req_bus.operation == OpRoundRobin || req_bus.last_byte);
   assign rsp_free   = !rsp_valid_ff || rsp_bus.ready;

   // checksum accumulators see key bytes only
   assign crc_cmd.fold     = req_accept && (req_bus.operation == OpKeyByte);
   assign crc_cmd.last     = req_bus.last_byte;
   assign crc_cmd.key_byte = req_bus.key_byte;

   khr_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .cmd   (crc_cmd),
      .slot  (key_slot)
   );

   // slot is left-aligned so only its 14 bits are stepped through
   assign mod_cmd.start    = job_start;
   assign mod_cmd.dividend = (req_bus.operation == OpRoundRobin)
                             ? rr_ff : {key_slot, {(DivW-SlotW){1'b0}}};
   assign mod_cmd.steps    = (req_bus.operation == OpRoundRobin) ? RrSteps : KeySteps;
   assign mod_cmd.divisor  = eff_count;

   khr_mod_unit u_mod (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mod_cmd),
      .status (mod_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!mod_status.busy && rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_DIVIDE: begin
            rsp_load = !mod_status.busy && rsp_free;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   // config, counter and job capture
   always_comb begin
      count_in    = csr_wr_en ? csr_wr_data : count_ff;
      rr_in       = rr_ff;
      job_rr_in   = job_rr_ff;
      job_none_in = job_none_ff;
      job_slot_in = job_slot_ff;
      if (job_start) begin
         job_rr_in   = (req_bus.operation == OpRoundRobin);
         job_none_in = (eff_count == '0);
         job_slot_in = (req_bus.operation == OpRoundRobin) ? '0 : key_slot;
         // counter moves only when a shard is actually picked
         if (req_bus.operation == OpRoundRobin && eff_count != '0) begin
            rr_in = rr_ff + 1'b1;
         end
      end
   end

   // output register, refilled the cycle it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_index_in = rsp_index_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_rr_in    = rsp_rr_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = job_none_ff ? '0 : mod_status.remainder[IndexW-1:0];
         rsp_slot_in  = job_slot_ff;
         rsp_none_in  = job_none_ff;
         rsp_rr_in    = job_rr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rr_ff        <= rr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_rr_ff    <= job_rr_in;
      job_none_ff  <= job_none_in;
      job_slot_ff  <= job_slot_in;
      rsp_index_ff <= rsp_index_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_rr_ff    <= rsp_rr_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.shard_index    = rsp_index_ff;
   assign rsp_bus.hash_slot      = rsp_slot_ff;
   assign rsp_bus.no_shard       = rsp_none_ff;
   assign rsp_bus.by_round_robin = rsp_rr_ff;

endmodule

// ===== hdl/khr_crc_unit.sv =====
// whole-key and hash-tag crc-16 accumulators with brace tracking
module khr_crc_unit import khr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  crc_cmd_type      cmd,
   output logic [SlotW-1:0] slot
);

   logic [CrcW-1:0] whole_ff, whole_in;
   logic [CrcW-1:0] tag_ff, tag_in;
   tag_phase_type   phase_ff, phase_in;
   logic            nonempty_ff, nonempty_in;

   logic [CrcW-1:0] whole_next, tag_next;
   tag_phase_type   phase_next;
   logic            nonempty_next;

   function automatic logic [CrcW-1:0] crc_fold(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] b);
      logic [CrcW-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < ByteW; i++) begin
         if (c[CrcW-1]) begin
            c = (c << 1) ^ CrcPoly;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   always_comb begin
      whole_next    = whole_ff;
      tag_next      = tag_ff;
      phase_next    = phase_ff;
      nonempty_next = nonempty_ff;
      if (cmd.fold) begin
         whole_next = crc_fold(whole_ff, cmd.key_byte);
         unique case (phase_ff)
            TAG_SEEK: begin
               if (cmd.key_byte == OpenBrace) begin
                  phase_next = TAG_INSIDE;
               end
            end
            TAG_INSIDE: begin
               if (cmd.key_byte == CloseBrace) begin
                  phase_next = TAG_CLOSED;
               end else begin
                  tag_next      = crc_fold(tag_ff, cmd.key_byte);
                  nonempty_next = 1'b1;
               end
            end
            TAG_CLOSED: begin
               phase_next = TAG_CLOSED;
            end
            default: begin
               phase_next = TAG_SEEK;
            end
         endcase
      end
   end

   // slot including the current byte, used when it closes the key
   assign slot = (phase_next == TAG_CLOSED && nonempty_next) ? tag_next[SlotW-1:0]
                                                             : whole_next[SlotW-1:0];

   always_comb begin
      if (cmd.fold && cmd.last) begin
         whole_in    = '0;
         tag_in      = '0;
         phase_in    = TAG_SEEK;
         nonempty_in = 1'b0;
      end else begin
         whole_in    = whole_next;
         tag_in      = tag_next;
         phase_in    = phase_next;
         nonempty_in = nonempty_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff    <= '0;
         tag_ff      <= '0;
         phase_ff    <= TAG_SEEK;
         nonempty_ff <= 1'b0;
      end else begin
         whole_ff    <= whole_in;
         tag_ff      <= tag_in;
         phase_ff    <= phase_in;
         nonempty_ff <= nonempty_in;
      end
   end

endmodule

// ===== hdl/khr_mod_unit.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
module khr_mod_unit import khr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  mod_cmd_type    cmd,
   output mod_status_type status
);

   logic [DivW-1:0]   quo_ff, quo_in;
   logic [CountW-1:0] rem_ff, rem_in;
   logic [CountW-1:0] div_ff, div_in;
   logic [StepW-1:0]  left_ff, left_in;

   logic [CountW:0]   trial;
   logic [CountW-1:0] rem_step;

   always_comb begin
      trial = {rem_ff, quo_ff[DivW-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_step = CountW'(trial - {1'b0, div_ff});
      end else begin
         rem_step = trial[CountW-1:0];
      end
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      left_in = left_ff;
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         div_in  = cmd.divisor;
         left_in = cmd.steps;
      end else if (left_ff != '0) begin
         quo_in  = quo_ff << 1;
         rem_in  = rem_step;
         left_in = left_ff - 1'b1;
      end
   end

   assign status.busy      = (left_ff != '0);
   assign status.remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

// ===== hdl/khr_checker.sv =====
// port-level checks of the router, bound to the top level
`include "key_hash_tag_shard_router_macros.svh"

module khr_checker import khr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_operation,
   input logic              req_last_byte,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [IndexW-1:0] rsp_shard_index,
   input logic [SlotW-1:0]  rsp_hash_slot,
   input logic              rsp_no_shard,
   input logic              rsp_by_round_robin
);

   `KHR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_shard_index) && $stable(rsp_hash_slot) && $stable(rsp_no_shard) && $stable(rsp_by_round_robin), "stalled response beat changed")
   `KHR_ASSERT_NEXT(a_busy_after_job, req_valid && req_ready && (req_operation || req_last_byte), !req_ready, "request taken while remainder runs")
   `KHR_ASSERT_SAME(a_rr_slot_zero, rsp_valid && rsp_by_round_robin, rsp_hash_slot == '0, "round-robin beat with nonzero slot")
   `KHR_ASSERT_SAME(a_none_index_zero, rsp_valid && rsp_no_shard, rsp_shard_index == '0, "no-shard beat with nonzero index")

endmodule

bind key_hash_tag_shard_router khr_checker u_khr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_operation      (req_bus.operation),
   .req_last_byte      (req_bus.last_byte),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_shard_index    (rsp_bus.shard_index),
   .rsp_hash_slot      (rsp_bus.hash_slot),
   .rsp_no_shard       (rsp_bus.no_shard),
   .rsp_by_round_robin (rsp_bus.by_round_robin)
);
